// ----- sv/rilp_pkg.sv -----
// Shared types, phase codes and character helpers for the radix integer literal parser.
// No dependencies; every other file in this folder imports this package.
package rilp_pkg;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_START  = 3'd1;
    localparam logic [2:0] PH_MINUS  = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_PREFIX = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;

    localparam logic [1:0] MODE_OCT = 2'd0;
    localparam logic [1:0] MODE_DEC = 2'd1;
    localparam logic [1:0] MODE_HEX = 2'd2;
    localparam logic [1:0] MODE_BIN = 2'd3;
    localparam logic [1:0] MODE_RESET = MODE_DEC;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic       begin_literal;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic [31:0] parsed_value;
        logic        parse_status;
        logic [7:0]  chars_consumed;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    // Digit value of a character, valid only when it lies below the radix of the mode.
    function automatic digit_t digit_of(logic [1:0] mode, logic [7:0] c);
        digit_t d;
        logic   in_radix;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_LO_A + 8'd10);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_UP_A + 8'd10);
        end
        case (mode)
            MODE_OCT: in_radix = (d.val < 4'd8);
            MODE_DEC: in_radix = (d.val < 4'd10);
            MODE_HEX: in_radix = 1'b1;
            default:  in_radix = (d.val < 4'd2);
        endcase
        d.ok = d.ok && in_radix;
        return d;
    endfunction

    // Accumulator times the radix plus one digit, built from shifts and adds.
    function automatic logic [31:0] shift_add(logic [1:0] mode, logic [31:0] acc,
                                              logic [3:0] dig);
        logic [31:0] scaled;
        case (mode)
            MODE_OCT: scaled = {acc[28:0], 3'b000};
            MODE_DEC: scaled = {acc[28:0], 3'b000} + {acc[30:0], 1'b0};
            MODE_HEX: scaled = {acc[27:0], 4'b0000};
            default:  scaled = {acc[30:0], 1'b0};
        endcase
        return scaled + {28'd0, dig};
    endfunction

endpackage

// ----- sv/radix_integer_literal_parser_core.sv -----
// Top level of the radix integer literal parser: input register, parse step, result register.
// Depends on rilp_pkg, rilp_in_stage, rilp_parse_fsm and rilp_out_stage.
// Throughput: one character per cycle unless stalled; the parse step is one shift-add.
// A terminating character is registered at the input, then its result in the result register.
// A terminating character stalls in the input register only while a prior result is not taken.
// Reset: radix mode returns to decimal, the parser to idle, both registers empty.
module radix_integer_literal_parser_core
    import rilp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               begin_literal,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] parsed_value,
    output logic               parse_status,
    output logic [7:0]         chars_consumed,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         radix_mode
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    step_en;
    logic    emit;
    logic    out_free;
    result_t result;
    result_t held;

    assign in_item.begin_literal = begin_literal;
    assign in_item.char_code     = char_code;
    assign cfg_ready             = 1'b1;

    rilp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .step_en    (step_en),
        .item_valid (item_valid),
        .item       (item)
    );

    rilp_parse_fsm u_parse_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_mode   (radix_mode),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .step_en    (step_en),
        .emit       (emit),
        .result     (result)
    );

    rilp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step_en && emit),
        .result    (result),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held      (held)
    );

    assign parsed_value   = signed'(held.parsed_value);
    assign parse_status   = held.parse_status;
    assign chars_consumed = held.chars_consumed;

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> item_valid && emit && out_valid && !out_ready)
        else $error("input stalled without a pending result");

endmodule

// ----- sv/rilp_in_stage.sv -----
// Input register of the literal parser: holds one accepted character until the parse step takes it.
// Depends on rilp_pkg for the item type.
module rilp_in_stage
    import rilp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  step_en,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register frees up in the same cycle the parse step consumes its character.
    assign in_ready   = !valid_reg || step_en;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !step_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- sv/rilp_parse_fsm.sv -----
// Parse state machine: phase, accumulator, sign and count registers plus the per-character step.
// Depends on rilp_pkg for phase codes, mode codes, digit decode and the shift-add helper.
module rilp_parse_fsm
    import rilp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_mode,
    input  logic       item_valid,
    input  item_t      item,
    input  logic       out_free,
    output logic       step_en,
    output logic       emit,
    output result_t    result
);

    logic [1:0]  mode_reg;
    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        neg_reg;
    logic        neg_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;

    logic [2:0]  phase_eff;
    logic [31:0] acc_eff;
    logic        neg_eff;
    logic [7:0]  count_eff;
    logic [7:0]  count_inc;
    logic [31:0] acc_step;
    logic        ok;
    logic        is_prefix;
    digit_t      dig;
    logic [7:0]  c;

    assign c   = item.char_code;
    assign dig = digit_of(mode_reg, c);

    // A begin flag restarts the parse from a cleared state on this very character.
    assign phase_eff = item.begin_literal ? PH_START : phase_reg;
    assign acc_eff   = item.begin_literal ? 32'd0 : acc_reg;
    assign neg_eff   = item.begin_literal ? 1'b0 : neg_reg;
    assign count_eff = item.begin_literal ? 8'd0 : count_reg;

    assign count_inc = (count_eff == COUNT_MAX) ? count_eff : count_eff + 8'd1;
    assign acc_step  = shift_add(mode_reg, acc_eff, dig.val);
    assign is_prefix = (mode_reg == MODE_HEX && (c == CH_LO_X || c == CH_UP_X)) ||
                       (mode_reg == MODE_BIN && (c == CH_LO_B || c == CH_UP_B));

    always_comb
    begin
        phase_next = phase_eff;
        acc_next   = acc_eff;
        neg_next   = neg_eff;
        count_next = count_eff;
        emit       = 1'b0;
        ok         = 1'b0;
        case (phase_eff)
            PH_START:
            begin
                if (mode_reg == MODE_DEC && c == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    count_next = count_inc;
                    phase_next = PH_MINUS;
                end
                else if ((mode_reg == MODE_HEX || mode_reg == MODE_BIN) && c == CH_ZERO)
                begin
                    count_next = count_inc;
                    phase_next = PH_ZERO;
                end
                else if (dig.ok)
                begin
                    acc_next   = acc_step;
                    count_next = count_inc;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_MINUS, PH_PREFIX:
            begin
                if (dig.ok)
                begin
                    acc_next   = acc_step;
                    count_next = count_inc;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_ZERO:
            begin
                if (is_prefix)
                begin
                    count_next = count_inc;
                    phase_next = PH_PREFIX;
                end
                else if (dig.ok)
                begin
                    acc_next   = acc_step;
                    count_next = count_inc;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    emit = 1'b1;
                    ok   = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                if (dig.ok)
                begin
                    acc_next   = acc_step;
                    count_next = count_inc;
                end
                else
                begin
                    emit = 1'b1;
                    ok   = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        if (emit)
        begin
            phase_next = PH_IDLE;
        end
    end

    // A terminating character waits while the result register is still occupied.
    assign step_en = item_valid && (!emit || out_free);

    always_comb
    begin
        result.parse_status   = !ok;
        result.chars_consumed = count_eff;
        if (!ok)
        begin
            result.parsed_value = 32'd0;
        end
        else if (neg_eff)
        begin
            result.parsed_value = 32'd0 - acc_eff;
        end
        else
        begin
            result.parsed_value = acc_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            phase_reg <= PH_IDLE;
            acc_reg   <= 32'd0;
            neg_reg   <= 1'b0;
            count_reg <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_mode;
            end
            if (step_en)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                count_reg <= count_next;
            end
        end
    end

    a_emit_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && emit |=> phase_reg == PH_IDLE)
        else $error("parser did not return to idle after a result");

    a_digits_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DIGITS || phase_reg == PH_MINUS || phase_reg == PH_ZERO ||
         phase_reg == PH_PREFIX) |-> count_reg != 8'd0)
        else $error("open literal with an empty character count");

endmodule

// ----- sv/rilp_out_stage.sv -----
// Result register of the literal parser: holds one finished result until the consumer takes it.
// Depends on rilp_pkg for the result type.
module rilp_out_stage
    import rilp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    out_free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t held
);

    logic    valid_reg;
    result_t result_reg;

    assign out_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = result_reg;

    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && result_reg.parse_status |-> result_reg.parsed_value == 32'd0)
        else $error("failed parse carries a nonzero value");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !valid_reg || out_ready)
        else $error("result register overwritten before its transfer");

endmodule

// ----- tb/literal_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the radix integer literal parser: follows the input, configuration
// and result transfers, predicts every result and compares it field by field.
// Depends on rilp_pkg for the phase, mode and character constants and the result type.
module literal_result_checker
    import rilp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        begin_literal,
    input  logic [7:0]  char_code,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] parsed_value,
    input  logic        parse_status,
    input  logic [7:0]  chars_consumed,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  radix_mode,
    output int          error_count,
    output int          pending_results
);

    localparam int unsigned NOT_DIGIT = 255;

    logic [1:0]  mode_q;
    logic [2:0]  phase_q;
    logic [31:0] acc_q;
    logic        neg_q;
    logic [7:0]  count_q;
    result_t     expected_results[$];
    result_t     head;

    function automatic int unsigned base_of(logic [1:0] mode);
        case (mode)
            MODE_OCT: return 8;
            MODE_DEC: return 10;
            MODE_HEX: return 16;
            default:  return 2;
        endcase
    endfunction

    function automatic int unsigned digit_in(logic [1:0] mode, logic [7:0] c);
        int unsigned d;
        d = NOT_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = c - CH_ZERO;
        end
        else if (c >= CH_LO_A && c <= CH_LO_F)
        begin
            d = c - CH_LO_A + 10;
        end
        else if (c >= CH_UP_A && c <= CH_UP_F)
        begin
            d = c - CH_UP_A + 10;
        end
        if (d >= base_of(mode))
        begin
            d = NOT_DIGIT;
        end
        return d;
    endfunction

    task automatic count_char();
        if (count_q != COUNT_MAX)
        begin
            count_q = count_q + 8'd1;
        end
    endtask

    task automatic take_digit(int unsigned d);
        acc_q = acc_q * base_of(mode_q) + d;
        count_char();
        phase_q = PH_DIGITS;
    endtask

    // A failed literal reports zero but keeps the count of characters taken before it.
    task automatic close_literal(logic ok);
        result_t r;
        r.parsed_value   = ok ? (neg_q ? 32'd0 - acc_q : acc_q) : 32'd0;
        r.parse_status   = !ok;
        r.chars_consumed = count_q;
        expected_results.push_back(r);
        phase_q = PH_IDLE;
    endtask

    task automatic parse_char(logic start, logic [7:0] c);
        int unsigned d;
        d = digit_in(mode_q, c);
        if (start)
        begin
            phase_q = PH_START;
            acc_q   = 32'd0;
            neg_q   = 1'b0;
            count_q = 8'd0;
        end
        case (phase_q)
            PH_START:
            begin
                if (mode_q == MODE_DEC && c == CH_MINUS)
                begin
                    neg_q = 1'b1;
                    count_char();
                    phase_q = PH_MINUS;
                end
                else if ((mode_q == MODE_HEX || mode_q == MODE_BIN) && c == CH_ZERO)
                begin
                    count_char();
                    phase_q = PH_ZERO;
                end
                else if (d != NOT_DIGIT)
                begin
                    take_digit(d);
                end
                else
                begin
                    close_literal(1'b0);
                end
            end
            PH_MINUS, PH_PREFIX:
            begin
                if (d != NOT_DIGIT)
                begin
                    take_digit(d);
                end
                else
                begin
                    close_literal(1'b0);
                end
            end
            PH_ZERO:
            begin
                // The prefix letter is only recognized in the mode that owns it.
                if ((mode_q == MODE_HEX && (c == CH_LO_X || c == CH_UP_X)) ||
                    (mode_q == MODE_BIN && (c == CH_LO_B || c == CH_UP_B)))
                begin
                    count_char();
                    phase_q = PH_PREFIX;
                end
                else if (d != NOT_DIGIT)
                begin
                    take_digit(d);
                end
                else
                begin
                    close_literal(1'b1);
                end
            end
            PH_DIGITS:
            begin
                if (d != NOT_DIGIT)
                begin
                    take_digit(d);
                end
                else
                begin
                    close_literal(1'b1);
                end
            end
            default:
            begin
                phase_q = PH_IDLE;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q  = MODE_RESET;
            phase_q = PH_IDLE;
            acc_q   = 32'd0;
            neg_q   = 1'b0;
            count_q = 8'd0;
            expected_results.delete();
            error_count     = 0;
            pending_results = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with none expected: value %0d status %0d count %0d",
                           $signed(parsed_value), parse_status, chars_consumed);
                    error_count++;
                end
                else
                begin
                    head = expected_results.pop_front();
                    if (parsed_value !== head.parsed_value)
                    begin
                        $error("parsed_value: expected %0d, got %0d",
                               $signed(head.parsed_value), $signed(parsed_value));
                        error_count++;
                    end
                    if (parse_status !== head.parse_status)
                    begin
                        $error("parse_status: expected %0d, got %0d",
                               head.parse_status, parse_status);
                        error_count++;
                    end
                    if (chars_consumed !== head.chars_consumed)
                    begin
                        $error("chars_consumed: expected %0d, got %0d",
                               head.chars_consumed, chars_consumed);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                mode_q = radix_mode;
            end
            if (in_valid && in_ready)
            begin
                parse_char(begin_literal, char_code);
            end
            pending_results = expected_results.size();
        end
    end

endmodule

// ----- tb/tb_radix_integer_literal_parser_core.sv -----
`timescale 1ns / 100ps
// Top of the parser testbench: clock, reset, character stimulus, radix changes and verdict.
// Depends on rilp_pkg, the parser core and literal_result_checker for all result checks.
module tb_radix_integer_literal_parser_core;
    import rilp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int DRAIN_CYCLES = 6;
    localparam int TARGET_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 2000000;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               begin_literal = 1'b0;
    logic [7:0]         char_code     = CH_NUL;
    logic               out_ready     = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic [1:0]         radix_mode    = MODE_RESET;
    logic               in_ready;
    logic               out_valid;
    logic signed [31:0] parsed_value;
    logic               parse_status;
    logic [7:0]         chars_consumed;
    logic               cfg_ready;

    int         errors;
    int         pending;
    int         chars_sent = 0;
    int         cycles     = 0;
    int         ready_left = 0;
    logic [1:0] cur_mode   = MODE_RESET;
    bit         steady     = 1'b0;

    radix_integer_literal_parser_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .begin_literal  (begin_literal),
        .char_code      (char_code),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .parsed_value   (parsed_value),
        .parse_status   (parse_status),
        .chars_consumed (chars_consumed),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .radix_mode     (radix_mode)
    );

    literal_result_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .begin_literal   (begin_literal),
        .char_code       (char_code),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .parsed_value    (parsed_value),
        .parse_status    (parse_status),
        .chars_consumed  (chars_consumed),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .radix_mode      (radix_mode),
        .error_count     (errors),
        .pending_results (pending)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $error("run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short gap, rarely a long pause; never a gap in the steady phase.
    function automatic int idle_cycles();
        int pick;
        if (steady)
        begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            return 0;
        end
        if (pick < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    // Result side: bursts of ready, broken by stalls of random length.
    always @(posedge clk)
    begin
        if (ready_left > 0)
        begin
            ready_left--;
        end
        else if (!steady && $urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            ready_left = idle_cycles();
        end
        else
        begin
            out_ready <= 1'b1;
            ready_left = $urandom_range(0, 15);
        end
    end

    task automatic send_char(input logic start, input logic [7:0] c);
        int gap;
        in_valid      <= 1'b1;
        begin_literal <= start;
        char_code     <= c;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        chars_sent++;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(i == 0, s[i]);
        end
    endtask

    // The radix is only changed once every result is out and the pipeline is empty.
    task automatic set_mode(input logic [1:0] m);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid  <= 1'b1;
        radix_mode <= m;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    function automatic logic [7:0] rand_digit(logic [1:0] mode);
        int unsigned d;
        case (mode)
            MODE_OCT: d = $urandom_range(0, 7);
            MODE_DEC: d = $urandom_range(0, 9);
            MODE_HEX: d = $urandom_range(0, 15);
            default:  d = $urandom_range(0, 1);
        endcase
        if (d < 10)
        begin
            return CH_ZERO + 8'(d);
        end
        return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(d - 10);
    endfunction

    function automatic logic [7:0] pick_end();
        case ($urandom_range(0, 4))
            0:       return CH_NUL;
            1:       return CH_SPACE;
            2:       return CH_COMMA;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] junk_char();
        case ($urandom_range(0, 7))
            0:       return CH_ZERO;
            1:       return CH_MINUS;
            2:       return $urandom_range(0, 1) ? CH_LO_X : CH_UP_X;
            3:       return $urandom_range(0, 1) ? CH_LO_B : CH_UP_B;
            4:       return rand_digit(2'($urandom_range(0, 3)));
            5:       return CH_NUL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // A well-formed literal for the current radix, with an occasional restart
    // or radix change in the middle.
    task automatic send_number();
        int n;
        int split;
        bit first;
        n = ($urandom_range(0, 59) == 0) ? $urandom_range(256, 300) : $urandom_range(1, 12);
        split = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
        first = 1'b1;
        if (cur_mode == MODE_DEC && $urandom_range(0, 2) == 0)
        begin
            send_char(1'b1, CH_MINUS);
            first = 1'b0;
        end
        else if (cur_mode == MODE_HEX && $urandom_range(0, 1) == 1)
        begin
            send_char(1'b1, CH_ZERO);
            send_char(1'b0, $urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            first = 1'b0;
        end
        else if (cur_mode == MODE_BIN && $urandom_range(0, 1) == 1)
        begin
            send_char(1'b1, CH_ZERO);
            send_char(1'b0, $urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
            first = 1'b0;
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == split)
            begin
                set_mode(2'($urandom_range(0, 3)));
            end
            send_char(first || $urandom_range(0, 39) == 0, rand_digit(cur_mode));
            first = 1'b0;
        end
        send_char(1'b0, pick_end());
    endtask

    task automatic send_junk();
        int n;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
        begin
            send_char(i == 0 || $urandom_range(0, 15) == 0, junk_char());
        end
    endtask

    initial
    begin
        int next_switch;
        int pick;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Decimal: sign, failure after the minus, failing first byte, stray byte
        // while idle, and a restart in the middle of a literal.
        send_text("-7 ");
        send_text("-q");
        send_char(1'b1, 8'hFF);
        send_char(1'b0, CH_ONE);
        send_text("12");
        send_text("3");
        send_char(1'b0, CH_NUL);

        // Hex and binary prefixes, failure right after a prefix, and a lone zero.
        set_mode(MODE_HEX);
        send_text("0Xa");
        send_char(1'b0, CH_NUL);
        send_text("0xg");
        set_mode(MODE_BIN);
        send_text("0B2");
        send_text("02");
        set_mode(MODE_OCT);
        send_text("78");

        next_switch = chars_sent + 90;
        while (chars_sent < TARGET_ITEMS)
        begin
            if (chars_sent >= next_switch)
            begin
                set_mode(2'($urandom_range(0, 3)));
                next_switch = chars_sent + $urandom_range(40, 140);
            end
            steady = (chars_sent >= 500 && chars_sent < 650);
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                send_number();
            end
            else if (pick < 92)
            begin
                send_junk();
            end
            else
            begin
                send_char(1'b0, junk_char());
            end
        end

        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
